>>> src/dbrf_pkg.sv
package dbrf_pkg;

    localparam int MAX_COLUMNS = 32;
    localparam int TBL_AW      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    // result kinds
    localparam logic [2:0] K_NULL = 3'd0;
    localparam logic [2:0] K_INT  = 3'd1;
    localparam logic [2:0] K_REAL = 3'd2;
    localparam logic [2:0] K_BLOB = 3'd3;
    localparam logic [2:0] K_TEXT = 3'd4;
    localparam logic [2:0] K_END  = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_HLEN  = 3'd1;
    localparam logic [2:0] ST_BAD_VINT  = 3'd2;
    localparam logic [2:0] ST_TOO_MANY  = 3'd3;
    localparam logic [2:0] ST_BODY_TRNC = 3'd4;
    localparam logic [2:0] ST_HDR_INC   = 3'd5;

    localparam logic [63:0] T_REAL  = 64'd7;
    localparam logic [63:0] T_ZERO  = 64'd8;
    localparam logic [63:0] T_ONE   = 64'd9;
    localparam logic [63:0] T_BYTES = 64'd12;

    typedef enum logic [3:0] {
        P_HLEN  = 4'b0001,
        P_HSER  = 4'b0010,
        P_BODY  = 4'b0100,
        P_DRAIN = 4'b1000
    } t_phase;

    typedef enum logic [4:0] {
        S_IN    = 5'b00001,
        S_ADV   = 5'b00010,
        S_CHK   = 5'b00100,
        S_EOR   = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

    typedef struct packed {
        logic [2:0]  kind;
        logic [5:0]  col;
        logic [63:0] val;
        logic [7:0]  dbyte;
        logic        bvalid;
        logic        clast;
        logic [2:0]  status;
    } t_res;

    function automatic logic [62:0] type_size(input logic [63:0] t);
        logic [62:0] sz;
        sz = '0;
        if (t >= T_BYTES) begin
            sz = 63'((t - T_BYTES) >> 1);
        end else begin
            case (t[3:0])
                4'd1:    sz = 63'd1;
                4'd2:    sz = 63'd2;
                4'd3:    sz = 63'd3;
                4'd4:    sz = 63'd4;
                4'd5:    sz = 63'd6;
                4'd6:    sz = 63'd8;
                4'd7:    sz = 63'd8;
                default: sz = 63'd0;
            endcase
        end
        return sz;
    endfunction

    function automatic logic [63:0] sext(input logic [63:0] v, input logic [63:0] t);
        logic [63:0] r;
        case (t[3:0])
            4'd1:    r = {{56{v[7]}}, v[7:0]};
            4'd2:    r = {{48{v[15]}}, v[15:0]};
            4'd3:    r = {{40{v[23]}}, v[23:0]};
            4'd4:    r = {{32{v[31]}}, v[31:0]};
            4'd5:    r = {{16{v[47]}}, v[47:0]};
            default: r = v;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] bytes_kind(input logic [63:0] t, input logic utf8);
        return (!t[0] || !utf8) ? K_BLOB : K_TEXT;
    endfunction

endpackage

>>> src/database_record_field_decoder_core.sv
// Record field decoder: takes one record payload byte per input transaction
// (i_payload_byte, i_end_of_record) and gives a stream of result transactions
// (kind, column index, value bits, data byte, flags, status, run_last).
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low. The user must set the text/blob choice for odd serial types
// through i_cfg_we/i_cfg_wdata only while the block is idle; the block does not
// enforce this. Reset sets it to text. A byte that yields a result and ends no
// column and not the record shows it on the output in the cycle after it is
// taken. Each serial-type lookup in the column table has a read issue step and
// an evaluate step, as the table has a registered read port; every zero-size
// column passes both. A column switch runs the lookup of the next non-empty
// column and then a flush step for the held result. A byte flagged end of
// record passes the record-end step and the final flush; the last result of
// a byte leaves a one-deep hold stage only when the byte's work is done, so
// run_last is known.
// While the receiver stalls with a result in the output register, one more may
// wait in the hold stage; the input stalls, and steps that move a result wait.
// Synchronous reset clears the control state except r_type; payload and the column table need no clear.
module database_record_field_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_end_of_record,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [5:0]  o_column_index,
    output logic [63:0] o_value_bits,
    output logic [7:0]  o_data_byte,
    output logic        o_byte_valid,
    output logic        o_column_last,
    output logic [2:0]  o_status,
    output logic        o_run_last
);

    // control state
    dbrf_pkg::t_state r_state, n_state;
    dbrf_pkg::t_phase r_phase, n_phase;
    logic        r_utf8;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_hlen, n_hlen;
    logic [63:0] r_vacc, n_vacc;
    logic [3:0]  r_vcnt, n_vcnt;
    logic [5:0]  r_count, n_count;
    logic [5:0]  r_cur, n_cur;
    logic [62:0] r_left, n_left;
    logic [63:0] r_iacc, n_iacc;
    logic [2:0]  r_err, n_err;
    logic        r_eor, n_eor;
    logic [63:0] r_type, n_type;
    logic        r_hv, n_hv;
    logic        r_ov, n_ov;
    // payload
    dbrf_pkg::t_res r_hold, n_hold;
    dbrf_pkg::t_res r_out, n_out;
    logic        r_rl, n_rl;

    logic        out_free, in_rdy, in_acc;
    logic [63:0] vt_acc;
    logic        vt_done;
    logic        tb_we, tb_re;
    logic [63:0] tb_rdata;
    logic [62:0] chk_sz;
    logic        bad_h;
    dbrf_pkg::t_res r0;
    logic        r0v, adv, bdone;

    assign out_free   = !r_ov || !i_out_stall;
    assign in_rdy     = (r_state == dbrf_pkg::S_IN) && out_free;
    assign in_acc     = i_in_valid && in_rdy;
    assign o_in_stall = !in_rdy;

    // varint byte step
    always_comb begin
        if (r_vcnt < 4'd8) begin
            vt_acc  = {r_vacc[56:0], i_payload_byte[6:0]};
            vt_done = !i_payload_byte[7];
        end else begin
            vt_acc  = {r_vacc[55:0], i_payload_byte};
            vt_done = 1'b1;
        end
    end

    assign bad_h  = (vt_acc == 64'd0) || (vt_acc[63:32] != 32'd0)
                    || (vt_acc < {32'd0, r_pos + 32'd1});
    assign chk_sz = dbrf_pkg::type_size(tb_rdata);

    dbrf_table u_table (
        .i_clk   (i_clk),
        .i_we    (tb_we),
        .i_waddr (r_count[dbrf_pkg::TBL_AW-1:0]),
        .i_wdata (vt_acc),
        .i_re    (tb_re),
        .i_raddr (r_cur[dbrf_pkg::TBL_AW-1:0]),
        .o_rdata (tb_rdata)
    );

    always_comb begin
        n_state = r_state;  n_phase = r_phase;  n_pos  = r_pos;   n_hlen = r_hlen;
        n_vacc  = r_vacc;   n_vcnt  = r_vcnt;   n_count = r_count; n_cur = r_cur;
        n_left  = r_left;   n_iacc  = r_iacc;   n_err  = r_err;   n_eor  = r_eor;
        n_type  = r_type;   n_hv    = r_hv;     n_hold = r_hold;
        n_ov    = r_ov && i_out_stall;
        n_out   = r_out;    n_rl    = r_rl;
        tb_we   = 1'b0;     tb_re   = 1'b0;
        r0      = '0;       r0v     = 1'b0;     adv    = 1'b0;
        bdone   = (r_left == 63'd1);

        case (r_state)
            dbrf_pkg::S_IN: begin
                if (in_acc) begin
                    n_eor = i_end_of_record;
                    case (r_phase)
                        dbrf_pkg::P_HLEN: begin
                            n_pos  = r_pos + 32'd1;
                            n_vacc = vt_acc;
                            n_vcnt = r_vcnt + 4'd1;
                            if (vt_done) begin
                                n_vacc = '0;
                                n_vcnt = '0;
                                if (bad_h) begin
                                    n_err   = dbrf_pkg::ST_BAD_HLEN;
                                    n_phase = dbrf_pkg::P_DRAIN;
                                end else begin
                                    n_hlen = vt_acc[31:0];
                                    if (vt_acc[31:0] == r_pos + 32'd1) begin
                                        n_cur = '0;
                                        adv   = 1'b1;
                                    end else begin
                                        n_phase = dbrf_pkg::P_HSER;
                                    end
                                end
                            end
                        end
                        dbrf_pkg::P_HSER: begin
                            n_pos  = r_pos + 32'd1;
                            n_vacc = vt_acc;
                            n_vcnt = r_vcnt + 4'd1;
                            if (vt_done) begin
                                n_vacc = '0;
                                n_vcnt = '0;
                                if (r_count >= 6'(dbrf_pkg::MAX_COLUMNS)) begin
                                    n_err   = dbrf_pkg::ST_TOO_MANY;
                                    n_phase = dbrf_pkg::P_DRAIN;
                                end else begin
                                    tb_we   = 1'b1;
                                    n_count = r_count + 6'd1;
                                end
                            end
                            if (!(vt_done && r_count >= 6'(dbrf_pkg::MAX_COLUMNS))
                                && (r_pos + 32'd1 == r_hlen)) begin
                                if (!vt_done) begin
                                    n_err   = dbrf_pkg::ST_BAD_VINT;
                                    n_phase = dbrf_pkg::P_DRAIN;
                                end else begin
                                    n_cur = '0;
                                    adv   = 1'b1;
                                end
                            end
                        end
                        dbrf_pkg::P_BODY: begin
                            n_iacc = {r_iacc[55:0], i_payload_byte};
                            n_left = r_left - 63'd1;
                            r0.col = r_cur;
                            if (r_type >= dbrf_pkg::T_BYTES) begin
                                r0v       = 1'b1;
                                r0.kind   = dbrf_pkg::bytes_kind(r_type, r_utf8);
                                r0.dbyte  = i_payload_byte;
                                r0.bvalid = 1'b1;
                                r0.clast  = bdone;
                            end else if (bdone) begin
                                r0v      = 1'b1;
                                r0.clast = 1'b1;
                                if (r_type == dbrf_pkg::T_REAL) begin
                                    r0.kind = dbrf_pkg::K_REAL;
                                    r0.val  = n_iacc;
                                end else begin
                                    r0.kind = dbrf_pkg::K_INT;
                                    r0.val  = dbrf_pkg::sext(n_iacc, r_type);
                                end
                            end
                            if (bdone) begin
                                n_cur = r_cur + 6'd1;
                                adv   = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    if (adv || i_end_of_record) begin
                        if (r0v) begin
                            n_hold = r0;
                            n_hv   = 1'b1;
                        end
                        n_state = adv ? dbrf_pkg::S_ADV : dbrf_pkg::S_EOR;
                    end else if (r0v) begin
                        n_out = r0;
                        n_rl  = 1'b1;
                        n_ov  = 1'b1;
                    end
                end
            end
            dbrf_pkg::S_ADV: begin
                if (r_cur < r_count) begin
                    tb_re   = 1'b1;
                    n_state = dbrf_pkg::S_CHK;
                end else begin
                    n_phase = dbrf_pkg::P_DRAIN;
                    n_state = r_eor ? dbrf_pkg::S_EOR : dbrf_pkg::S_FLUSH;
                end
            end
            dbrf_pkg::S_CHK: begin
                if (chk_sz != 63'd0) begin
                    n_left  = chk_sz;
                    n_type  = tb_rdata;
                    n_iacc  = '0;
                    n_phase = dbrf_pkg::P_BODY;
                    n_state = r_eor ? dbrf_pkg::S_EOR : dbrf_pkg::S_FLUSH;
                end else if (!r_hv || out_free) begin
                    r0.col   = r_cur;
                    r0.clast = 1'b1;
                    if (tb_rdata == dbrf_pkg::T_ZERO || tb_rdata == dbrf_pkg::T_ONE) begin
                        r0.kind = dbrf_pkg::K_INT;
                        r0.val  = {63'd0, tb_rdata[0]};
                    end else if (tb_rdata >= dbrf_pkg::T_BYTES) begin
                        r0.kind = dbrf_pkg::bytes_kind(tb_rdata, r_utf8);
                    end else begin
                        r0.kind = dbrf_pkg::K_NULL;
                    end
                    if (r_hv) begin
                        n_out = r_hold;
                        n_rl  = 1'b0;
                        n_ov  = 1'b1;
                    end
                    n_hold  = r0;
                    n_hv    = 1'b1;
                    n_cur   = r_cur + 6'd1;
                    n_state = dbrf_pkg::S_ADV;
                end
            end
            dbrf_pkg::S_EOR: begin
                if (!r_hv || out_free) begin
                    r0.kind = dbrf_pkg::K_END;
                    r0.col  = r_count;
                    if (r_err != dbrf_pkg::ST_OK) begin
                        r0.status = r_err;
                    end else if (r_phase == dbrf_pkg::P_HLEN || r_phase == dbrf_pkg::P_HSER) begin
                        r0.status = dbrf_pkg::ST_HDR_INC;
                    end else if (r_phase == dbrf_pkg::P_BODY) begin
                        r0.status = dbrf_pkg::ST_BODY_TRNC;
                    end
                    if (r_hv) begin
                        n_out = r_hold;
                        n_rl  = 1'b0;
                        n_ov  = 1'b1;
                    end
                    n_hold  = r0;
                    n_hv    = 1'b1;
                    // back to a fresh record
                    n_phase = dbrf_pkg::P_HLEN;
                    n_pos   = '0;  n_hlen = '0;  n_vacc = '0;  n_vcnt = '0;
                    n_count = '0;  n_cur  = '0;  n_left = '0;  n_iacc = '0;
                    n_err   = dbrf_pkg::ST_OK;
                    n_eor   = 1'b0;
                    n_state = dbrf_pkg::S_FLUSH;
                end
            end
            dbrf_pkg::S_FLUSH: begin
                if (!r_hv) begin
                    n_state = dbrf_pkg::S_IN;
                end else if (out_free) begin
                    n_out   = r_hold;
                    n_rl    = 1'b1;
                    n_ov    = 1'b1;
                    n_hv    = 1'b0;
                    n_state = dbrf_pkg::S_IN;
                end
            end
            default: n_state = dbrf_pkg::S_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dbrf_pkg::S_IN;
            r_phase <= dbrf_pkg::P_HLEN;
            r_utf8  <= 1'b1;
            r_pos   <= '0;
            r_hlen  <= '0;
            r_vacc  <= '0;
            r_vcnt  <= '0;
            r_count <= '0;
            r_cur   <= '0;
            r_left  <= '0;
            r_iacc  <= '0;
            r_err   <= dbrf_pkg::ST_OK;
            r_eor   <= 1'b0;
            r_hv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            if (i_cfg_we) begin
                r_utf8 <= i_cfg_wdata;
            end
            r_pos   <= n_pos;
            r_hlen  <= n_hlen;
            r_vacc  <= n_vacc;
            r_vcnt  <= n_vcnt;
            r_count <= n_count;
            r_cur   <= n_cur;
            r_left  <= n_left;
            r_iacc  <= n_iacc;
            r_err   <= n_err;
            r_eor   <= n_eor;
            r_hv    <= n_hv;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type <= n_type;
        r_hold <= n_hold;
        r_out  <= n_out;
        r_rl   <= n_rl;
    end

    assign o_out_valid    = r_ov;
    assign o_kind         = r_out.kind;
    assign o_column_index = r_out.col;
    assign o_value_bits   = r_out.val;
    assign o_data_byte    = r_out.dbyte;
    assign o_byte_valid   = r_out.bvalid;
    assign o_column_last  = r_out.clast;
    assign o_status       = r_out.status;
    assign o_run_last     = r_rl;

    // hold stage is always drained before the next byte is taken
    a_hold_empty_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dbrf_pkg::S_IN) |-> !r_hv)
        else $error("hold stage busy while taking bytes");

    // a body column being fed bytes always has bytes left
    a_body_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dbrf_pkg::S_IN && r_phase == dbrf_pkg::P_BODY) |-> (r_left != 63'd0))
        else $error("body phase with no bytes left");

    // status is only reported on record end
    a_status_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.status != dbrf_pkg::ST_OK) |-> (r_out.kind == dbrf_pkg::K_END))
        else $error("status on non record-end result");

    // an end-of-record byte that does not advance to a column lookup goes straight to the record-end step
    a_eor_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_end_of_record && !adv) |=> (r_state == dbrf_pkg::S_EOR))
        else $error("end of record not handled");

    // column lookups stay within the stored column count
    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tb_re |-> (r_cur < r_count))
        else $error("table read beyond stored columns");

endmodule

>>> src/dbrf_table.sv
module dbrf_table (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [dbrf_pkg::TBL_AW-1:0] i_waddr,
    input  logic [63:0]              i_wdata,
    input  logic                     i_re,
    input  logic [dbrf_pkg::TBL_AW-1:0] i_raddr,
    output logic [63:0]              o_rdata
);

    logic [63:0] r_mem [dbrf_pkg::MAX_COLUMNS];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
